[hw/rtl/rvs_pkg.sv]
// Shared constants, types and register codes for the radial vignette shader.
`timescale 1ns / 1ps

package rvs_pkg;

	localparam int COORD_BITS     = 13;
	localparam int CHANNEL_BITS   = 16;
	localparam int FRAC_BITS      = 4;

	localparam int CENTRE_BITS    = 17;
	localparam int RADIUS_BITS    = 18;
	localparam int FADE_BITS      = 17;
	localparam int RECIP_BITS     = 24;
	localparam int CFG_DATA_BITS  = 24;
	localparam int CFG_INDEX_BITS = 3;

	localparam logic [CENTRE_BITS-1:0] CENTRE_RESET = CENTRE_BITS'(65536);
	localparam logic [FRAC_BITS-1:0]   HALF_PIXEL   = FRAC_BITS'(1 << (FRAC_BITS - 1));

	localparam int POS_BITS   = COORD_BITS + FRAC_BITS;
	localparam int DELTA_BITS = (POS_BITS > CENTRE_BITS) ? POS_BITS : CENTRE_BITS;
	localparam int SQR_BITS   = 2 * DELTA_BITS;
	localparam int SUM_BITS   = SQR_BITS + 1;

	localparam int SQRT_DIGITS_PER_STAGE = 2;
	localparam int SQRT_STAGES = (SUM_BITS + 2 * SQRT_DIGITS_PER_STAGE - 1)
		/ (2 * SQRT_DIGITS_PER_STAGE);
	localparam int ROOT_BITS = SQRT_STAGES * SQRT_DIGITS_PER_STAGE;
	localparam int RAD_BITS  = 2 * ROOT_BITS;
	localparam int REM_BITS  = ROOT_BITS + 2;

	localparam int SHADE_FRAC = 16;
	localparam int SHADE_BITS = SHADE_FRAC + 1;
	localparam logic [SHADE_BITS-1:0] SHADE_ONE = SHADE_BITS'(1 << SHADE_FRAC);

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		CFG_CENTRE_X = 3'd0,
		CFG_CENTRE_Y = 3'd1,
		CFG_RADIUS   = 3'd2,
		CFG_FADE     = 3'd3,
		CFG_RECIP    = 3'd4,
		CFG_INVERT   = 3'd5
	} cfg_index_t;

	typedef struct packed {
		logic [CHANNEL_BITS-1:0] red;
		logic [CHANNEL_BITS-1:0] green;
		logic [CHANNEL_BITS-1:0] blue;
		logic [CHANNEL_BITS-1:0] alpha;
	} rgba_t;

endpackage

[hw/rtl/rvs_sqrt_pipe.sv]
// Pipelined digit-by-digit integer square root that carries the pixel colour alongside.
`timescale 1ns / 1ps

module rvs_sqrt_pipe import rvs_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  logic                 in_valid,
	input  logic [SUM_BITS-1:0]  radicand,
	input  rgba_t                in_rgba,
	output logic                 out_valid,
	output logic [ROOT_BITS-1:0] root,
	output rgba_t                out_rgba
);

	logic                 valid_s [SQRT_STAGES];
	logic [REM_BITS-1:0]  rem_s   [SQRT_STAGES];
	logic [ROOT_BITS-1:0] root_s  [SQRT_STAGES];
	logic [RAD_BITS-1:0]  rad_s   [SQRT_STAGES];
	rgba_t                rgba_s  [SQRT_STAGES];

	for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_stage
		logic                 valid_in;
		logic [REM_BITS-1:0]  rem_in;
		logic [ROOT_BITS-1:0] root_in;
		logic [RAD_BITS-1:0]  rad_in;
		rgba_t                rgba_in;
		logic [REM_BITS-1:0]  rem_c;
		logic [ROOT_BITS-1:0] root_c;
		logic [RAD_BITS-1:0]  rad_c;

		if (g == 0) begin : g_first
			assign valid_in = in_valid;
			assign rem_in   = '0;
			assign root_in  = '0;
			assign rad_in   = RAD_BITS'(radicand);
			assign rgba_in  = in_rgba;
		end else begin : g_next
			assign valid_in = valid_s[g-1];
			assign rem_in   = rem_s[g-1];
			assign root_in  = root_s[g-1];
			assign rad_in   = rad_s[g-1];
			assign rgba_in  = rgba_s[g-1];
		end

		always_comb begin : step
			logic [REM_BITS-1:0] trial;
			rem_c  = rem_in;
			root_c = root_in;
			trial  = '0;
			for (int k = 0; k < SQRT_DIGITS_PER_STAGE; k++) begin
				rem_c = {rem_c[REM_BITS-3:0], rad_in[RAD_BITS-1-2*k -: 2]};
				trial = {root_c, 2'b01};
				if (rem_c >= trial) begin
					rem_c  = rem_c - trial;
					root_c = {root_c[ROOT_BITS-2:0], 1'b1};
				end else begin
					root_c = {root_c[ROOT_BITS-2:0], 1'b0};
				end
			end
			rad_c = {rad_in[RAD_BITS-1-2*SQRT_DIGITS_PER_STAGE:0],
				{(2 * SQRT_DIGITS_PER_STAGE){1'b0}}};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[g] <= 1'b0;
			end else if (adv) begin
				valid_s[g] <= valid_in;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[g]  <= rem_c;
				root_s[g] <= root_c;
				rad_s[g]  <= rad_c;
				rgba_s[g] <= rgba_in;
			end
		end
	end

	assign out_valid = valid_s[SQRT_STAGES-1];
	assign root      = root_s[SQRT_STAGES-1];
	assign out_rgba  = rgba_s[SQRT_STAGES-1];

endmodule

[hw/rtl/radial_vignette_shader_core.sv]
// Top level of the radial vignette shader: configuration, shade pipeline and output buffer.
`timescale 1ns / 1ps

// Scales each premultiplied RGBA pixel by a radial shade that is full inside the configured
// radius, falls off along a smoothstep curve across the fade band and is zero beyond it; when
// invert is set, the shade is one minus that value. One pixel is taken every clock while
// in_stall is low; the square root unit forms nine stages of the pipeline. A one-entry skid
// buffer behind the output register lets the pipeline keep running after out_stall rises until
// a result has to wait there, and in_stall follows from that buffer being full. Configuration
// registers must only be written while the pipeline is empty.
module radial_vignette_shader_core import rvs_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wr_en,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [COORD_BITS-1:0]     pixel_x,
	input  logic [COORD_BITS-1:0]     pixel_y,
	input  logic [CHANNEL_BITS-1:0]   in_red,
	input  logic [CHANNEL_BITS-1:0]   in_green,
	input  logic [CHANNEL_BITS-1:0]   in_blue,
	input  logic [CHANNEL_BITS-1:0]   in_alpha,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [CHANNEL_BITS-1:0]   out_red,
	output logic [CHANNEL_BITS-1:0]   out_green,
	output logic [CHANNEL_BITS-1:0]   out_blue,
	output logic [CHANNEL_BITS-1:0]   out_alpha
);

	localparam int DIFF_BITS  = FADE_BITS;
	localparam int T24_BITS   = DIFF_BITS + RECIP_BITS;
	localparam int T24_FRAC   = 24;
	localparam int T_SHIFT    = T24_FRAC - SHADE_FRAC;
	localparam int TT_BITS    = 2 * SHADE_BITS;
	localparam int M_BITS     = SHADE_BITS + 1;
	localparam int PM_BITS    = SHADE_BITS + M_BITS;
	localparam int P_BITS     = PM_BITS - SHADE_FRAC;
	localparam int PROD_BITS  = CHANNEL_BITS + SHADE_BITS;

	localparam logic [M_BITS-1:0]    THREE_ONE  = M_BITS'(3 * (1 << SHADE_FRAC));
	localparam logic [PM_BITS-1:0]   ROUND_HALF = PM_BITS'(1 << (SHADE_FRAC - 1));
	localparam logic [T24_FRAC:0]    T_ROUND    = (T24_FRAC + 1)'(1 << (T_SHIFT - 1));

	typedef enum logic [1:0] {
		KIND_FULL,
		KIND_ZERO,
		KIND_BAND
	} shade_kind_t;

	logic [CENTRE_BITS-1:0] centre_x_q;
	logic [CENTRE_BITS-1:0] centre_y_q;
	logic [RADIUS_BITS-1:0] radius_q;
	logic [FADE_BITS-1:0]   fade_q;
	logic [RECIP_BITS-1:0]  recip_q;
	logic                   invert_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			centre_x_q <= CENTRE_RESET;
			centre_y_q <= CENTRE_RESET;
			radius_q   <= '0;
			fade_q     <= '0;
			recip_q    <= '0;
			invert_q   <= 1'b0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_CENTRE_X: centre_x_q <= cfg_data[CENTRE_BITS-1:0];
				CFG_CENTRE_Y: centre_y_q <= cfg_data[CENTRE_BITS-1:0];
				CFG_RADIUS:   radius_q   <= cfg_data[RADIUS_BITS-1:0];
				CFG_FADE:     fade_q     <= cfg_data[FADE_BITS-1:0];
				CFG_RECIP:    recip_q    <= cfg_data[RECIP_BITS-1:0];
				CFG_INVERT:   invert_q   <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	logic  adv;
	logic  skid_full_q;
	logic  out_valid_q;
	rgba_t out_rgba_q;
	rgba_t skid_rgba_q;

	assign adv      = !skid_full_q;
	assign in_stall = skid_full_q;

	// Stage 1: offsets from the centre.
	logic [DELTA_BITS-1:0] pos_x, pos_y, cen_x, cen_y, dx_c, dy_c;
	logic                  valid_s1;
	logic [DELTA_BITS-1:0] dx_s1, dy_s1;
	rgba_t                 rgba_s1;

	always_comb begin
		pos_x = DELTA_BITS'({pixel_x, HALF_PIXEL});
		pos_y = DELTA_BITS'({pixel_y, HALF_PIXEL});
		cen_x = DELTA_BITS'(centre_x_q);
		cen_y = DELTA_BITS'(centre_y_q);
		dx_c  = (pos_x >= cen_x) ? pos_x - cen_x : cen_x - pos_x;
		dy_c  = (pos_y >= cen_y) ? pos_y - cen_y : cen_y - pos_y;
	end

	// Stage 2: squares. Stage 3: sum.
	logic                  valid_s2, valid_s3;
	logic [SQR_BITS-1:0]   dx2_s2, dy2_s2;
	logic [SUM_BITS-1:0]   sum_s3;
	rgba_t                 rgba_s2, rgba_s3;

	// Stages after the square root.
	logic                  sq_valid;
	logic [ROOT_BITS-1:0]  root_dist;
	rgba_t                 sq_rgba;

	logic                  valid_s4, valid_s5, valid_s6, valid_s7, valid_s8, valid_s9;
	logic                  valid_s10, valid_s11;
	shade_kind_t           kind_c, kind_s4, kind_s5, kind_s6, kind_s7, kind_s8, kind_s9;
	logic [DIFF_BITS-1:0]  diff_s4;
	logic [T24_BITS-1:0]   t24_s5;
	logic [SHADE_BITS-1:0] t_c, t_s6;
	logic [TT_BITS-1:0]    tt_s7;
	logic [M_BITS-1:0]     m_s7, m_s8;
	logic [SHADE_BITS-1:0] t2_c, t2_s8;
	logic [PM_BITS-1:0]    pm_s9;
	logic [SHADE_BITS-1:0] shade_c, shade_s10;
	logic [PROD_BITS-1:0]  prod_r_s11, prod_g_s11, prod_b_s11, prod_a_s11;
	rgba_t                 rgba_s4, rgba_s5, rgba_s6, rgba_s7, rgba_s8, rgba_s9, rgba_s10;
	rgba_t                 round_c;

	logic [RADIUS_BITS:0]  dist_w, radius_w, diff_w;
	logic [T24_FRAC:0]     t_sum;
	logic [TT_BITS-1:0]    tt_sum;
	logic [PM_BITS-1:0]    pm_sum;
	logic [P_BITS-1:0]     p_c;
	logic [SHADE_BITS-1:0] base_c;

	rvs_sqrt_pipe u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (valid_s3),
		.radicand  (sum_s3),
		.in_rgba   (rgba_s3),
		.out_valid (sq_valid),
		.root      (root_dist),
		.out_rgba  (sq_rgba)
	);

	always_comb begin
		dist_w   = (RADIUS_BITS + 1)'(root_dist);
		radius_w = (RADIUS_BITS + 1)'(radius_q);
		diff_w   = dist_w - radius_w;
		if (dist_w <= radius_w) begin
			kind_c = KIND_FULL;
		end else if (fade_q == '0) begin
			kind_c = KIND_ZERO;
		end else if (diff_w >= (RADIUS_BITS + 1)'(fade_q)) begin
			kind_c = KIND_ZERO;
		end else begin
			kind_c = KIND_BAND;
		end

		t_sum = (T24_FRAC + 1)'(t24_s5[T24_FRAC-1:0]) + T_ROUND;
		t_c   = t_sum[T24_FRAC:T_SHIFT];

		tt_sum = tt_s7 + TT_BITS'(ROUND_HALF);
		t2_c   = tt_sum[SHADE_FRAC+SHADE_BITS-1:SHADE_FRAC];

		pm_sum = pm_s9 + ROUND_HALF;
		p_c    = pm_sum[PM_BITS-1:SHADE_FRAC];
		unique case (kind_s9)
			KIND_FULL: base_c = SHADE_ONE;
			KIND_ZERO: base_c = '0;
			KIND_BAND: base_c = (p_c > P_BITS'(SHADE_ONE)) ? '0
				: SHADE_ONE - p_c[SHADE_BITS-1:0];
			default:   base_c = '0;
		endcase
		shade_c = invert_q ? SHADE_ONE - base_c : base_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			valid_s3  <= 1'b0;
			valid_s4  <= 1'b0;
			valid_s5  <= 1'b0;
			valid_s6  <= 1'b0;
			valid_s7  <= 1'b0;
			valid_s8  <= 1'b0;
			valid_s9  <= 1'b0;
			valid_s10 <= 1'b0;
			valid_s11 <= 1'b0;
		end else if (adv) begin
			valid_s1  <= in_valid;
			valid_s2  <= valid_s1;
			valid_s3  <= valid_s2;
			valid_s4  <= sq_valid;
			valid_s5  <= valid_s4;
			valid_s6  <= valid_s5;
			valid_s7  <= valid_s6;
			valid_s8  <= valid_s7;
			valid_s9  <= valid_s8;
			valid_s10 <= valid_s9;
			valid_s11 <= valid_s10;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dx_s1      <= dx_c;
			dy_s1      <= dy_c;
			rgba_s1    <= '{red: in_red, green: in_green, blue: in_blue, alpha: in_alpha};

			dx2_s2     <= SQR_BITS'(dx_s1) * SQR_BITS'(dx_s1);
			dy2_s2     <= SQR_BITS'(dy_s1) * SQR_BITS'(dy_s1);
			rgba_s2    <= rgba_s1;

			sum_s3     <= SUM_BITS'(dx2_s2) + SUM_BITS'(dy2_s2);
			rgba_s3    <= rgba_s2;

			kind_s4    <= kind_c;
			diff_s4    <= diff_w[DIFF_BITS-1:0];
			rgba_s4    <= sq_rgba;

			kind_s5    <= kind_s4;
			t24_s5     <= T24_BITS'(diff_s4) * T24_BITS'(recip_q);
			rgba_s5    <= rgba_s4;

			kind_s6    <= (kind_s5 == KIND_BAND && t24_s5[T24_BITS-1:T24_FRAC] != '0)
				? KIND_ZERO : kind_s5;
			t_s6       <= t_c;
			rgba_s6    <= rgba_s5;

			kind_s7    <= kind_s6;
			tt_s7      <= TT_BITS'(t_s6) * TT_BITS'(t_s6);
			m_s7       <= THREE_ONE - {t_s6, 1'b0};
			rgba_s7    <= rgba_s6;

			kind_s8    <= kind_s7;
			t2_s8      <= t2_c;
			m_s8       <= m_s7;
			rgba_s8    <= rgba_s7;

			kind_s9    <= kind_s8;
			pm_s9      <= PM_BITS'(t2_s8) * PM_BITS'(m_s8);
			rgba_s9    <= rgba_s8;

			shade_s10  <= shade_c;
			rgba_s10   <= rgba_s9;

			prod_r_s11 <= PROD_BITS'(rgba_s10.red) * PROD_BITS'(shade_s10);
			prod_g_s11 <= PROD_BITS'(rgba_s10.green) * PROD_BITS'(shade_s10);
			prod_b_s11 <= PROD_BITS'(rgba_s10.blue) * PROD_BITS'(shade_s10);
			prod_a_s11 <= PROD_BITS'(rgba_s10.alpha) * PROD_BITS'(shade_s10);
		end
	end

	function automatic logic [CHANNEL_BITS-1:0] round_channel(input logic [PROD_BITS-1:0] prod);
		logic [PROD_BITS:0] sum;
		sum = (PROD_BITS + 1)'(prod) + (PROD_BITS + 1)'(ROUND_HALF);
		return sum[SHADE_FRAC+CHANNEL_BITS-1:SHADE_FRAC];
	endfunction

	assign round_c = '{
		red:   round_channel(prod_r_s11),
		green: round_channel(prod_g_s11),
		blue:  round_channel(prod_b_s11),
		alpha: round_channel(prod_a_s11)
	};

	// The output register reloads whenever its transaction is taken or it is empty; a result
	// leaving the pipeline while the output is stalled waits in the skid buffer.
	logic out_load;
	logic push;

	assign out_load = !out_valid_q || !out_stall;
	assign push     = adv && valid_s11;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_full_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= skid_full_q || push;
			skid_full_q <= 1'b0;
		end else if (push) begin
			skid_full_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_rgba_q <= skid_full_q ? skid_rgba_q : round_c;
		end else if (push) begin
			skid_rgba_q <= round_c;
		end
	end

	assign out_valid = out_valid_q;
	assign out_red   = out_rgba_q.red;
	assign out_green = out_rgba_q.green;
	assign out_blue  = out_rgba_q.blue;
	assign out_alpha = out_rgba_q.alpha;

endmodule
